// File: rtl/sacl_pkg.sv
// Shared types and fixed constants for the set-associative tag lookup.
// No dependencies; imported by set_assoc_cache_tag_lookup.
package sacl_pkg;

  localparam int ADDR_W    = 16;       // width of the address port
  localparam int OUT_WAY_W = 4;        // width of the reported way
  localparam int OUT_TAG_W = 10;       // width of the reported victim tag
  localparam int LFSR_W    = 16;

  localparam logic [LFSR_W-1:0] LFSR_RESET = 16'd43;
  localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } sacl_state_t;

endpackage

// File: rtl/set_assoc_cache_tag_lookup.sv
// Set-associative tag lookup with LFSR victim selection and in-place fill.
// Depends on sacl_pkg for the state type and the fixed port widths.

// An address is taken when start is high and busy is low. At the transfer the tag row of
// its set is read from the tag memory and its valid bits from flip-flops, both registered.
// In the LOOKUP state that follows, the tags are compared, a miss writes the victim way
// back into the same row, and the result is registered. out_valid marks the result for
// exactly one cycle, in the cycle after LOOKUP; the receiver cannot stall it. busy is high
// for the one cycle of the read-modify-write, so no new address is taken until it is over.
// The valid bits live in flip-flops and are cleared by reset at once, so no clearing pass
// is needed.
module set_assoc_cache_tag_lookup #(
  parameter int ADDR_BITS = 16,
  parameter int SET_BITS  = 4,
  parameter int LINE_BITS = 2,
  parameter int WAYS      = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sacl_pkg::ADDR_W-1:0]      in_address,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [sacl_pkg::OUT_WAY_W-1:0]   out_way,
  output logic                             out_victim_was_valid,
  output logic [sacl_pkg::OUT_TAG_W-1:0]   out_victim_tag
);
  import sacl_pkg::*;

  localparam int SETS     = 1 << SET_BITS;
  localparam int OFF_BITS = SET_BITS + LINE_BITS;
  localparam int TAG_W    = (ADDR_BITS > OFF_BITS) ? (ADDR_BITS - OFF_BITS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * TAG_W;
  localparam int EXT_W    = ADDR_W + 32;
  localparam logic [EXT_W-1:0] ADDR_MASK = (EXT_W'(1) << ADDR_BITS) - EXT_W'(1);
  // Reciprocal for the LFSR modulo; exact for every 16-bit value.
  localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));

  sacl_state_t state_r, state_nxt;

  logic [ROW_W-1:0]    tag_mem [SETS];
  logic [ROW_W-1:0]    rd_row_r;
  logic [WAYS-1:0]     valid_r [SETS];
  logic [WAYS-1:0]     vld_row_r;
  logic [TAG_W-1:0]    tag_r;
  logic [SET_BITS-1:0] set_r;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [LFSR_W-1:0]   quot_r;

  logic                out_valid_r, out_hit_r, out_vvalid_r;
  logic [OUT_WAY_W-1:0] out_way_r;
  logic [OUT_TAG_W-1:0] out_vtag_r;

  logic [EXT_W-1:0]    addr_ext;
  logic [TAG_W-1:0]    in_tag;
  logic [SET_BITS-1:0] in_set;
  logic [48:0]         prod;
  logic                accept;

  logic                hit_c;
  logic [WAY_W-1:0]    hit_way_c;
  logic [LFSR_W-1:0]   rem_c;
  logic [WAY_W-1:0]    victim_c;
  logic [TAG_W-1:0]    victim_tag_c;
  logic                victim_vld_c;
  logic [ROW_W-1:0]    wr_row_c;
  logic                do_fill;

  // Address split; bits at or above ADDR_BITS are dropped.
  assign addr_ext = EXT_W'(in_address) & ADDR_MASK;
  assign in_tag   = TAG_W'(addr_ext >> OFF_BITS);
  assign in_set   = SET_BITS'(addr_ext >> LINE_BITS);
  assign accept   = start && (state_r == ST_IDLE);
  assign prod     = 49'(lfsr_r) * 49'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    do_fill   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy      = 1'b1;
        do_fill   = !hit_c;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Tag memory: one row per set, read at the transfer, written back on a miss.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= tag_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (do_fill) begin
      tag_mem[set_r] <= wr_row_c;
    end
  end

  // Capture the request and the quotient of the LFSR; the LFSR only moves in LOOKUP.
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r     <= in_tag;
      set_r     <= in_set;
      vld_row_r <= valid_r[in_set];
      quot_r    <= LFSR_W'(prod >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
      lfsr_r <= LFSR_RESET;
    end else begin
      if (do_fill) begin
        valid_r[set_r][victim_c] <= 1'b1;
      end
      lfsr_r <= lfsr_nxt;
    end
  end

  // Compare, pick the victim, build the write-back row and the next LFSR state.
  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vld_row_r[w] && (rd_row_r[w*TAG_W +: TAG_W] == tag_r)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
    end

    rem_c        = lfsr_r - LFSR_W'(quot_r * LFSR_W'(WAYS));
    victim_c     = WAY_W'(rem_c);
    victim_vld_c = vld_row_r[victim_c];
    victim_tag_c = rd_row_r[32'(victim_c)*TAG_W +: TAG_W];

    wr_row_c = rd_row_r;
    wr_row_c[32'(victim_c)*TAG_W +: TAG_W] = tag_r;

    lfsr_nxt = lfsr_r;
    if (do_fill) begin
      lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_MASK : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP) begin
      out_hit_r <= hit_c;
      if (hit_c) begin
        out_way_r    <= OUT_WAY_W'(hit_way_c);
        out_vvalid_r <= 1'b0;
        out_vtag_r   <= '0;
      end else begin
        out_way_r    <= OUT_WAY_W'(victim_c);
        out_vvalid_r <= victim_vld_c;
        out_vtag_r   <= victim_vld_c ? OUT_TAG_W'(victim_tag_c) : '0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_way              = out_way_r;
  assign out_victim_was_valid = out_vvalid_r;
  assign out_victim_tag       = out_vtag_r;

  a_lookup_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |=> out_valid)
    else $error("lookup cycle did not produce a result strobe");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_victim_was_valid && (out_victim_tag == '0)))
    else $error("hit reported victim information");

  a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_way) < WAYS))
    else $error("reported way out of range");

  a_lfsr_moves_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_LOOKUP) && !hit_c) |=> (lfsr_r != $past(lfsr_r)))
    else $error("LFSR did not advance on a miss");

  a_lfsr_holds_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !do_fill |=> (lfsr_r == $past(lfsr_r)))
    else $error("LFSR moved without a fill");

endmodule
